FILE: design/fvcw_pkg.sv
package fvcw_pkg;

  localparam int FLOW_W       = 16;
  localparam int ANGLE_ITER   = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int CORDIC_STEPS = (ANGLE_ITER < ATAN_ENTRIES) ? ANGLE_ITER : ATAN_ENTRIES;
  localparam int STEP_W       = $clog2(ATAN_ENTRIES);
  localparam int SQ_W         = 2 * FLOW_W - 1;
  localparam int SUM_W        = 2 * FLOW_W + 1;
  localparam int FRAC_W       = 16;
  localparam int RADIUS_W     = FRAC_W + 1;
  localparam int ROOT_W       = (SQ_W + FRAC_W + 1) / 2;
  localparam int RAD_W        = 2 * ROOT_W;
  localparam int CORDIC_W     = FLOW_W + 8 + 3;
  localparam int TURN_W       = 32;
  localparam int WHEEL_SIZE   = 55;
  localparam int KIDX_W       = 6;
  localparam int COLOR_W      = 8;
  localparam int V_W          = COLOR_W + FRAC_W;
  localparam int CNT_W        = $clog2(((ROOT_W > ATAN_ENTRIES) ? ROOT_W : ATAN_ENTRIES) + 1);
  localparam int Q_DEPTH      = 2;
  localparam int QPTR_W       = $clog2(Q_DEPTH);

  typedef struct packed {
    logic                     unknown;
    logic signed [FLOW_W-1:0] flow_x;
    logic signed [FLOW_W-1:0] flow_y;
    logic [SQ_W-1:0]          sq;
    logic [SQ_W-1:0]          max_sq;
  } q_item_t;

  localparam logic [COLOR_W-1:0] WHEEL_R [WHEEL_SIZE] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43,
    8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd19, 8'd39, 8'd58, 8'd78, 8'd98, 8'd117, 8'd137, 8'd156, 8'd176,
    8'd196, 8'd215, 8'd235,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
  };

  localparam logic [COLOR_W-1:0] WHEEL_G [WHEEL_SIZE] = '{
    8'd0, 8'd17, 8'd34, 8'd51, 8'd68, 8'd85, 8'd102, 8'd119, 8'd136, 8'd153,
    8'd170, 8'd187, 8'd204, 8'd221, 8'd238,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd232, 8'd209, 8'd186, 8'd163, 8'd140, 8'd116, 8'd93, 8'd70, 8'd47, 8'd24,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  localparam logic [COLOR_W-1:0] WHEEL_B [WHEEL_SIZE] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd63, 8'd127, 8'd191,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
    8'd255, 8'd255, 8'd255,
    8'd255, 8'd213, 8'd170, 8'd128, 8'd85, 8'd43
  };

  // arctangent of 2^-i in Q0.32 turns
  function automatic logic [TURN_W-1:0] atan_turns(input logic [STEP_W-1:0] i);
    logic [TURN_W-1:0] a;
    unique case (i)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

FILE: design/flow_vector_to_color_wheel_core.sv
// Path: an accepted colorize request passes the input stage, dispatch, 16 CORDIC steps,
//   two 24-step square roots, a 17-step radius division, wheel position, blend and shade;
//   unknown vectors, a zero maximum or a vector beyond the maximum skip roots and division.
// Throughput: measure requests take one per cycle unless a colorize request waits for room;
//   the shared back sequencer takes one colorize request at a time. Reset: synchronous
//   active-low rst_n clears valid flags, queue pointers, running maximum and sequencer state.
module flow_vector_to_color_wheel_core import fvcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // flow_x [15:0], flow_y [31:16]
  input  logic [2:0]  in_tuser,   // command [0], frame_start [1], unknown [2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // red [7:0], green [15:8], blue [23:16]
);

  logic    push, q_full, q_pop, q_valid;
  q_item_t push_item, q_head;
  logic [COLOR_W-1:0] red, green, blue;

  // front: square, saturate and track the running maximum; forward colorize requests
  fvcw_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .command     (in_tuser[0]),
    .frame_start (in_tuser[1]),
    .flow_x      (in_tdata[15:0]),
    .flow_y      (in_tdata[31:16]),
    .unknown     (in_tuser[2]),
    .push        (push),
    .push_item   (push_item),
    .q_full      (q_full)
  );

  // short queue, each entry carries the maximum seen at dispatch time
  fvcw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // back: angle, radius and color blend, with a held output register
  fvcw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule

FILE: design/fvcw_front.sv
module fvcw_front import fvcw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     command,
  input  logic                     frame_start,
  input  logic signed [FLOW_W-1:0] flow_x,
  input  logic signed [FLOW_W-1:0] flow_y,
  input  logic                     unknown,
  output logic                     push,
  output q_item_t                  push_item,
  input  logic                     q_full
);

  logic                     s1_valid_r;
  logic                     s1_cmd_r, s1_start_r, s1_unk_r;
  logic signed [FLOW_W-1:0] s1_x_r, s1_y_r;
  logic [2*FLOW_W-1:0]      s1_xx_r, s1_yy_r;
  logic [SQ_W-1:0]          max_r, max_nxt, base;
  logic signed [2*FLOW_W-1:0] xx_full, yy_full;
  logic [SUM_W-1:0]         sum;
  logic [SQ_W-1:0]          sq;
  logic                     s1_done;

  assign xx_full = flow_x * flow_x;
  assign yy_full = flow_y * flow_y;

  assign sum = {1'b0, s1_xx_r} + {1'b0, s1_yy_r};
  assign sq  = (sum[SUM_W-1:SQ_W] != '0) ? {SQ_W{1'b1}} : sum[SQ_W-1:0];

  // measure items retire at once; colorize items wait for queue room
  assign s1_done  = s1_valid_r && (!s1_cmd_r || !q_full);
  assign in_ready = !s1_valid_r || s1_done;
  assign push     = s1_done && s1_cmd_r;

  assign push_item.unknown = s1_unk_r;
  assign push_item.flow_x  = s1_x_r;
  assign push_item.flow_y  = s1_y_r;
  assign push_item.sq      = sq;
  assign push_item.max_sq  = max_r;

  always_comb begin
    base    = s1_start_r ? '0 : max_r;
    max_nxt = max_r;
    if (s1_done && !s1_cmd_r) begin
      max_nxt = (!s1_unk_r && sq > base) ? sq : base;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      max_r      <= '0;
    end else begin
      max_r <= max_nxt;
      if (in_ready) s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r   <= command;
      s1_start_r <= frame_start;
      s1_unk_r   <= unknown;
      s1_x_r     <= flow_x;
      s1_y_r     <= flow_y;
      s1_xx_r    <= xx_full;
      s1_yy_r    <= yy_full;
    end
  end

endmodule

FILE: design/fvcw_queue.sv
module fvcw_queue import fvcw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    not_empty,
  output q_item_t head
);

  q_item_t             mem_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_r, rd_r;
  logic [QPTR_W:0]     cnt_r;

  assign full      = (cnt_r == (QPTR_W+1)'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_item;
  end

endmodule

FILE: design/fvcw_back.sv
module fvcw_back import fvcw_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  q_item_t            q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] red,
  output logic [COLOR_W-1:0] green,
  output logic [COLOR_W-1:0] blue
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ANGLE = 3'd1;
  localparam logic [2:0] ST_ROOT  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_POS   = 3'd4;
  localparam logic [2:0] ST_MIX   = 3'd5;
  localparam logic [2:0] ST_SHADE = 3'd6;

  localparam logic [V_W-1:0]        FULL_Q = V_W'(255) << FRAC_W;
  localparam logic [FRAC_W:0]       ONE_Q  = (FRAC_W+1)'(1) << FRAC_W;

  logic [2:0]                 st_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       unk_r, beyond_r, zero_r, root_sel_r;
  logic [SQ_W-1:0]            sq_r, max_r;
  logic signed [CORDIC_W-1:0] cx_r, cy_r, dx, dy, xs, ys;
  logic [TURN_W-1:0]          z_r;
  logic [RAD_W-1:0]           n_r, res_r, bit_r, trial;
  logic                       root_ge;
  logic [ROOT_W-1:0]          m_r, mm_r;
  logic [ROOT_W:0]            rem_r, rem_sh;
  logic                       div_ge;
  logic [RADIUS_W-1:0]        rad_r;
  logic [TURN_W+KIDX_W-1:0]   pos;
  logic [KIDX_W-1:0]          k0_r, k1_r, k0c;
  logic [FRAC_W-1:0]          f_r;
  logic [V_W-1:0]             v_r [3];
  logic [V_W:0]               v_sum [3];
  logic [COLOR_W-1:0]         c0 [3], c1 [3];
  logic [COLOR_W-1:0]         shade [3];
  logic                       out_valid_r;
  logic [COLOR_W-1:0]         red_r, green_r, blue_r;
  logic                       load_out;

  assign q_pop     = (st_r == ST_IDLE) && q_valid;
  assign load_out  = (st_r == ST_SHADE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;

  assign xs = CORDIC_W'(q_head.flow_x) <<< 8;
  assign ys = CORDIC_W'(q_head.flow_y) <<< 8;

  // floor shifts
  assign dx = cy_r >>> cnt_r;
  assign dy = cx_r >>> cnt_r;

  assign trial   = res_r + bit_r;
  assign root_ge = (n_r >= trial);

  assign rem_sh = {rem_r[ROOT_W-1:0], (cnt_r == '0) ? m_r[0] : 1'b0};
  assign div_ge = (rem_sh >= {1'b0, mm_r});

  assign pos = TURN_W'(z_r) * (TURN_W+KIDX_W)'(WHEEL_SIZE - 1);
  assign k0c = (pos[TURN_W+KIDX_W-1:TURN_W] >= KIDX_W'(WHEEL_SIZE))
             ? KIDX_W'(WHEEL_SIZE - 1) : pos[TURN_W+KIDX_W-1:TURN_W];

  always_comb begin
    c0[0] = WHEEL_R[k0_r]; c0[1] = WHEEL_G[k0_r]; c0[2] = WHEEL_B[k0_r];
    c1[0] = WHEEL_R[k1_r]; c1[1] = WHEEL_G[k1_r]; c1[2] = WHEEL_B[k1_r];
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [V_W-1:0]          w;
    logic [RADIUS_W+V_W-1:0] p;
    logic [V_W+1:0]          v3;
    logic [V_W-1:0]          t;

    assign v_sum[ch] = (V_W+1)'(c0[ch] * (ONE_Q - {1'b0, f_r}))
                     + (V_W+1)'(c1[ch] * f_r);
    assign w  = FULL_Q - v_r[ch];
    assign p  = rad_r * w;
    assign v3 = (V_W+2)'(v_r[ch]) * (V_W+2)'(3);
    assign t  = FULL_Q - V_W'(p >> FRAC_W);

    always_comb begin
      priority if (unk_r)  shade[ch] = '0;
      else if (beyond_r)   shade[ch] = v3[V_W+1:V_W-COLOR_W+2];
      else                 shade[ch] = t[V_W-1:FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (load_out) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE:  if (q_valid) st_r <= ST_ANGLE;
        ST_ANGLE: if (cnt_r == CNT_W'(CORDIC_STEPS - 1))
                    st_r <= (zero_r || beyond_r || unk_r) ? ST_POS : ST_ROOT;
        ST_ROOT:  if (root_sel_r && cnt_r == CNT_W'(ROOT_W - 1)) st_r <= ST_DIV;
        ST_DIV:   if (cnt_r == CNT_W'(RADIUS_W - 1)) st_r <= ST_POS;
        ST_POS:   st_r <= ST_MIX;
        ST_MIX:   st_r <= ST_SHADE;
        ST_SHADE: if (load_out) st_r <= ST_IDLE;
        default:  st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      ST_IDLE: begin
        unk_r      <= q_head.unknown;
        sq_r       <= q_head.sq;
        max_r      <= q_head.max_sq;
        zero_r     <= (q_head.max_sq == '0);
        beyond_r   <= (q_head.max_sq != '0) && (q_head.sq > q_head.max_sq);
        rad_r      <= '0;
        cnt_r      <= '0;
        root_sel_r <= 1'b0;
        // half-turn pre-rotation for the left half plane
        if (q_head.flow_x < 0) begin
          cx_r <= -xs;
          cy_r <= -ys;
          z_r  <= TURN_W'(1) << (TURN_W - 1);
        end else begin
          cx_r <= xs;
          cy_r <= ys;
          z_r  <= '0;
        end
      end
      ST_ANGLE: begin
        if (cy_r >= 0) begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          z_r  <= z_r + atan_turns(cnt_r[STEP_W-1:0]);
        end else begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          z_r  <= z_r - atan_turns(cnt_r[STEP_W-1:0]);
        end
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          cnt_r <= '0;
          n_r   <= RAD_W'(sq_r) << FRAC_W;
          res_r <= '0;
          bit_r <= RAD_W'(1) << (RAD_W - 2);
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          cnt_r <= '0;
          if (root_sel_r) begin
            mm_r  <= root_ge ? ROOT_W'((res_r >> 1) + bit_r) : ROOT_W'(res_r >> 1);
            rem_r <= (ROOT_W+1)'(m_r >> 1);
          end else begin
            m_r        <= root_ge ? ROOT_W'((res_r >> 1) + bit_r) : ROOT_W'(res_r >> 1);
            root_sel_r <= 1'b1;
            n_r        <= RAD_W'(max_r) << FRAC_W;
            res_r      <= '0;
            bit_r      <= RAD_W'(1) << (RAD_W - 2);
          end
        end else begin
          cnt_r <= cnt_r + 1'b1;
          n_r   <= root_ge ? n_r - trial : n_r;
          res_r <= root_ge ? (res_r >> 1) + bit_r : res_r >> 1;
          bit_r <= bit_r >> 2;
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= div_ge ? rem_sh - {1'b0, mm_r} : rem_sh;
        rad_r <= {rad_r[RADIUS_W-2:0], div_ge};
      end
      ST_POS: begin
        k0_r <= k0c;
        k1_r <= (k0c == KIDX_W'(WHEEL_SIZE - 1)) ? '0 : k0c + 1'b1;
        f_r  <= pos[TURN_W-1:TURN_W-FRAC_W];
      end
      ST_MIX: begin
        for (int ch = 0; ch < 3; ch++) v_r[ch] <= v_sum[ch][V_W-1:0];
      end
      default: begin
      end
    endcase
    if (load_out) begin
      red_r   <= shade[0];
      green_r <= shade[1];
      blue_r  <= shade[2];
    end
  end

endmodule

FILE: design/fvcw_checker.sv
module fvcw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // held request must not drop
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("out request dropped");

  // held request must not change
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("out data changed");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid) else $error("output valid after reset");

  // a shaded color keeps one channel full; scaled colors stay at or below 191
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] == 8'd255 || out_tdata[15:8] == 8'd255 ||
                    out_tdata[23:16] == 8'd255 ||
                    (out_tdata[7:0] <= 8'd191 && out_tdata[15:8] <= 8'd191 &&
                     out_tdata[23:16] <= 8'd191)))
    else $error("color off the wheel");

endmodule

bind flow_vector_to_color_wheel_core fvcw_checker u_fvcw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
